[rtl/emwg_pkg.sv]
// ----------------------------------------------------------------------------
// emwg_pkg
// Shared widths and constants for the entropy mixing word generator.
// ----------------------------------------------------------------------------
`default_nettype none

package emwg_pkg;

    localparam int WORD_W  = 64;
    localparam int HALF_W  = WORD_W / 2;
    localparam int BYTES_W = 4;

    // seed offset and xorshift64* output multiplier
    localparam logic [WORD_W-1:0] SEED_CONST = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] STAR_MULT  = 64'h2545_F491_4F6C_DD1D;

    // xorshift shift amounts
    localparam int XS_SHIFT_A = 12;
    localparam int XS_SHIFT_B = 25;
    localparam int XS_SHIFT_C = 27;

    // tick shifts for seeding and mixing
    localparam int SEED_TICK_SHIFT = 17;
    localparam int MIX_TICK_SHIFT  = 9;

    localparam logic [BYTES_W-1:0] BYTES_MAX = 4'd8;

    typedef logic [WORD_W-1:0] word_t;

endpackage : emwg_pkg

`default_nettype wire

[rtl/entropy_mixing_word_generator.sv]
// ----------------------------------------------------------------------------
// entropy_mixing_word_generator
// One 64-bit mixed random word per request: hardware word or xorshift64*
// product, folded into a running mix with cycle count, tick and task tag.
// ----------------------------------------------------------------------------
//
//  channel   ports            direction  handshake
//  --------  ---------------  ---------  ---------------------------------
//  input     s_*              in         s_valid / s_ready
//  result    m_*              out        m_valid / m_ready
//  config    cfg_wr_*         in         cfg_wr_en, taken every cycle
//
//  one request accepted per cycle while s_ready is high, one result per request, in order
//  registered stages from accept to m_valid: state step, split multiply, mix
//  the fallback state is seeded or stepped at accept, so back-to-back requests chain
//  reset clears the fallback state, the running mix, the source flag, valids
//  each stage holds when the next one is full, so a stalled result does not
//  stop requests until all three stages are occupied
//
`default_nettype none

module entropy_mixing_word_generator (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_wr_data,
    // request channel
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_first_of_request,
    input  wire logic                         s_hw_ok,
    input  wire logic [emwg_pkg::WORD_W-1:0]  s_hw_word,
    input  wire logic [emwg_pkg::WORD_W-1:0]  s_cycle_count,
    input  wire logic [emwg_pkg::WORD_W-1:0]  s_tick_ms,
    input  wire logic [emwg_pkg::WORD_W-1:0]  s_task_tag,
    input  wire logic [emwg_pkg::BYTES_W-1:0] s_byte_count,
    // result channel
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [emwg_pkg::WORD_W-1:0]       m_out_word,
    output logic [emwg_pkg::BYTES_W-1:0]      m_valid_bytes
);
    import emwg_pkg::*;

    // hardware source present flag
    logic hw_present_reg;

    // xorshift state and running mix (mix doubles as the output word register)
    word_t fallback_reg, fallback_next;
    word_t mix_reg, mix_next;

    // stage 1: stepped state plus side terms
    logic                p1_valid_reg;
    logic                p1_use_hw_reg;
    logic                p1_first_reg;
    word_t               p1_state_reg;
    word_t               p1_hw_word_reg;
    word_t               p1_side_reg;
    logic [BYTES_W-1:0]  p1_bytes_reg;

    // stage 2: partial products
    logic                p2_valid_reg;
    logic                p2_use_hw_reg;
    logic                p2_first_reg;
    word_t               p2_ll_reg;
    logic [HALF_W-1:0]   p2_x1_reg;
    logic [HALF_W-1:0]   p2_x2_reg;
    word_t               p2_hw_word_reg;
    word_t               p2_side_reg;
    logic [BYTES_W-1:0]  p2_bytes_reg;

    // result stage
    logic                out_valid_reg;
    logic [BYTES_W-1:0]  out_bytes_reg;

    logic rdy_out, rdy_p2, s_fire, p1_move, p2_move;

    // backpressure: a stage can load when empty or when it moves on
    assign rdy_out = !out_valid_reg || m_ready;
    assign rdy_p2  = !p2_valid_reg || rdy_out;
    assign s_ready = !p1_valid_reg || rdy_p2;
    assign s_fire  = s_valid && s_ready;
    assign p1_move = p1_valid_reg && rdy_p2;
    assign p2_move = p2_valid_reg && rdy_out;

    // seed check, hardware path choice and one xorshift step at accept
    word_t seeded, xs_a, xs_b, xs_c, side_term;
    logic  use_hw;
    logic [BYTES_W-1:0] bytes_sat;

    always_comb begin
        if (fallback_reg == '0) begin
            seeded = s_cycle_count ^ (s_tick_ms << SEED_TICK_SHIFT) ^ SEED_CONST;
        end else begin
            seeded = fallback_reg;
        end
        xs_a = seeded ^ (seeded >> XS_SHIFT_A);
        xs_b = xs_a ^ (xs_a << XS_SHIFT_B);
        xs_c = xs_b ^ (xs_b >> XS_SHIFT_C);
        use_hw = hw_present_reg && s_hw_ok;
        // state is seeded either way but only stepped on the fallback path
        fallback_next = use_hw ? seeded : xs_c;
        side_term = s_cycle_count ^ (s_tick_ms << MIX_TICK_SHIFT) ^ s_task_tag;
        bytes_sat = (s_byte_count > BYTES_MAX) ? BYTES_MAX : s_byte_count;
    end

    // low 64 bits of state * multiplier, from three 32x32 partial products
    logic [HALF_W-1:0] st_lo, st_hi;
    word_t             ll_next;
    logic [HALF_W-1:0] x1_next, x2_next;

    always_comb begin
        st_lo   = p1_state_reg[HALF_W-1:0];
        st_hi   = p1_state_reg[WORD_W-1:HALF_W];
        ll_next = WORD_W'(st_lo) * WORD_W'(STAR_MULT[HALF_W-1:0]);
        x1_next = st_hi * STAR_MULT[HALF_W-1:0];
        x2_next = st_lo * STAR_MULT[WORD_W-1:HALF_W];
    end

    // final product sum and the mix update
    word_t product, mix_in;

    always_comb begin
        product = p2_ll_reg + {p2_x1_reg + p2_x2_reg, {HALF_W{1'b0}}};
        mix_in  = p2_use_hw_reg ? p2_hw_word_reg : product;
        mix_next = (p2_first_reg ? '0 : mix_reg) ^ mix_in ^ p2_side_reg;
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hw_present_reg <= 1'b0;
            fallback_reg   <= '0;
            mix_reg        <= '0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                hw_present_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                fallback_reg <= fallback_next;
            end
            if (p2_move) begin
                mix_reg <= mix_next;
            end
            if (s_ready) begin
                p1_valid_reg <= s_valid;
            end
            if (rdy_p2) begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (rdy_out) begin
                out_valid_reg <= p2_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_use_hw_reg  <= use_hw;
            p1_first_reg   <= s_first_of_request;
            p1_state_reg   <= fallback_next;
            p1_hw_word_reg <= s_hw_word;
            p1_side_reg    <= side_term;
            p1_bytes_reg   <= bytes_sat;
        end
        if (p1_move) begin
            p2_use_hw_reg  <= p1_use_hw_reg;
            p2_first_reg   <= p1_first_reg;
            p2_ll_reg      <= ll_next;
            p2_x1_reg      <= x1_next;
            p2_x2_reg      <= x2_next;
            p2_hw_word_reg <= p1_hw_word_reg;
            p2_side_reg    <= p1_side_reg;
            p2_bytes_reg   <= p1_bytes_reg;
        end
        if (p2_move) begin
            out_bytes_reg <= p2_bytes_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_out_word    = mix_reg;
    assign m_valid_bytes = out_bytes_reg;

endmodule : entropy_mixing_word_generator

`default_nettype wire

[rtl/emwg_checker.sv]
// ----------------------------------------------------------------------------
// emwg_checker
// Port-level checks for the entropy mixing word generator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module emwg_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [emwg_pkg::WORD_W-1:0]  m_out_word,
    input wire logic [emwg_pkg::BYTES_W-1:0] m_valid_bytes
);
    import emwg_pkg::*;

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result keeps its word and byte count
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_word)
                                && $stable(m_valid_bytes))
        else $error("stalled result changed");

    // byte count is saturated to one word
    a_bytes_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_valid_bytes <= BYTES_MAX)
        else $error("valid_bytes above eight");

    // no new result appears unless a request was accepted at one of the past samples checked below
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(m_valid) && !$past(s_fire, 1) && !$past(s_fire, 2)
        && !$past(s_fire, 3) |-> !m_valid)
        else $error("result without request");

endmodule : emwg_checker

bind entropy_mixing_word_generator emwg_checker u_emwg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_word    (m_out_word),
    .m_valid_bytes (m_valid_bytes)
);

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the entropy mixing word generator. A short table of
// directed requests is followed by random requests under random source and
// sink stalls. Every accepted request is run through a local xorshift64*
// predictor, and each result is compared in order against the oldest
// predicted word.
// ----------------------------------------------------------------------------

module testbench;

    import emwg_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_LIMIT    = 2000;
    localparam int LONG_HOLD     = 96;
    localparam int MAX_GAP       = 5;
    localparam int RAND_PHASES   = 5;
    localparam int PHASE_ITEMS   = 380;
    localparam int SETTLE_CYCLES = 16;
    localparam int N_DIRECTED    = 16;

    localparam word_t ONES = '1;

    typedef logic [BYTES_W-1:0] bytes_t;

    // one request as seen on the s_ side
    typedef struct packed {
        logic   first;
        logic   hw_ok;
        word_t  hw_word;
        word_t  cycle_count;
        word_t  tick_ms;
        word_t  task_tag;
        bytes_t byte_count;
    } request_t;

    // one result as seen on the m_ side
    typedef struct packed {
        word_t  out_word;
        bytes_t valid_bytes;
    } mixed_word_t;

    // directed row: source flag, request, which result fields are typed in
    typedef struct packed {
        logic        hw_cfg;
        request_t    req;
        logic        fixed_word;
        logic        fixed_bytes;
        mixed_word_t res;
    } table_row_t;

    // clock, reset and every block input known from time zero
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_valid     = 1'b0;
    request_t    s_req       = '0;
    logic        m_ready     = 1'b0;
    logic        s_ready;
    logic        m_valid;
    word_t       m_out_word;
    bytes_t      m_valid_bytes;

    // predictor state, mirrors the block's registers
    word_t       xs_state    = '0;
    word_t       mix_acc     = '0;
    logic        hw_enabled  = 1'b0;

    // words predicted but not yet seen on the result channel
    mixed_word_t pending_words [$];

    int          n_fail           = 0;
    int unsigned src_gap_max      = MAX_GAP;
    int unsigned sink_gap_max     = MAX_GAP;
    int unsigned long_holds_asked = 0;
    int unsigned long_holds_done  = 0;
    int unsigned hold_left        = 0;
    int unsigned idle_cycles      = 0;
    word_t       cycle_now        = '0;

    // directed requests
    // typed results: seed that works out zero, pure hardware words, and the byte
    // counts of most rows, saturation and zero among them; every other word and byte count comes from the predictor
    table_row_t dir_rows [N_DIRECTED] = '{
        // seed works out zero, state stays zero, product is zero
        '{1'b0, '{1'b1, 1'b0, 64'h0, SEED_CONST, 64'h0, 64'h0, 4'd8},
          1'b1, 1'b1, '{SEED_CONST, 4'd8}},
        // no first flag, mix carries on, seed zero again
        '{1'b0, '{1'b0, 1'b0, 64'h0, SEED_CONST, 64'h0, 64'h0, 4'd1},
          1'b1, 1'b1, '{64'h0, 4'd1}},
        // no source present: hw word ignored, real seed taken, zero bytes
        '{1'b0, '{1'b1, 1'b1, ONES, 64'h0, 64'h0, 64'h0, 4'd0},
          1'b0, 1'b1, '{64'h0, 4'd0}},
        // all-ones timestamps and task tag, byte count saturates
        '{1'b0, '{1'b0, 1'b0, 64'h0, ONES, ONES, ONES, 4'd15},
          1'b0, 1'b1, '{64'h0, 4'd8}},
        '{1'b0, '{1'b0, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                  64'h1, 64'h0, 4'd9},
          1'b0, 1'b1, '{64'h0, 4'd8}},
        '{1'b0, '{1'b1, 1'b0, 64'h0, 64'h0123_4567_89AB_CDEF,
                  64'h8000_0000_0000_0000, 64'hFEDC_BA98_7654_3210, 4'd1},
          1'b0, 1'b0, '{64'h0, 4'd0}},
        '{1'b0, '{1'b0, 1'b0, ONES, 64'h1, 64'h2, 64'h3, 4'd4},
          1'b0, 1'b0, '{64'h0, 4'd0}},
        // source present: hardware word goes straight into a cleared mix
        '{1'b1, '{1'b1, 1'b1, ONES, 64'h0, 64'h0, 64'h0, 4'd8},
          1'b1, 1'b1, '{ONES, 4'd8}},
        '{1'b1, '{1'b0, 1'b1, 64'h0, 64'h0, 64'h1, 64'h0, 4'd7},
          1'b1, 1'b1, '{64'hFFFF_FFFF_FFFF_FDFF, 4'd7}},
        '{1'b1, '{1'b1, 1'b1, 64'h0, 64'h0, 64'h0, ONES, 4'd2},
          1'b1, 1'b1, '{ONES, 4'd2}},
        '{1'b1, '{1'b1, 1'b1, 64'h1, 64'h8000_0000_0000_0000, 64'h0, 64'h0, 4'd3},
          1'b1, 1'b1, '{64'h8000_0000_0000_0001, 4'd3}},
        // tick top bits shifted out
        '{1'b1, '{1'b1, 1'b1, 64'h0, 64'h0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 4'd6},
          1'b1, 1'b1, '{64'hFFFF_FFFF_FFFF_FE00, 4'd6}},
        // source present but word flagged invalid: xorshift path
        '{1'b1, '{1'b1, 1'b0, ONES, 64'h0, 64'h0, 64'h0, 4'd5},
          1'b0, 1'b1, '{64'h0, 4'd5}},
        '{1'b1, '{1'b0, 1'b1, 64'hDEAD_BEEF_0BAD_F00D, ONES, ONES, ONES, 4'd15},
          1'b0, 1'b1, '{64'h0, 4'd8}},
        '{1'b1, '{1'b0, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 4'd0},
          1'b0, 1'b1, '{64'h0, 4'd0}},
        // source withdrawn again, hw word must be refused
        '{1'b0, '{1'b0, 1'b1, 64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0,
                  64'h0, 64'h0, 4'd3},
          1'b0, 1'b0, '{64'h0, 4'd0}}
    };

    entropy_mixing_word_generator dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_first_of_request (s_req.first),
        .s_hw_ok            (s_req.hw_ok),
        .s_hw_word          (s_req.hw_word),
        .s_cycle_count      (s_req.cycle_count),
        .s_tick_ms          (s_req.tick_ms),
        .s_task_tag         (s_req.task_tag),
        .s_byte_count       (s_req.byte_count),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_word         (m_out_word),
        .m_valid_bytes      (m_valid_bytes)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // predicted word for one accepted request, advances the local state
    function automatic mixed_word_t mix_word(input request_t r);
        mixed_word_t res;
        if (r.first) begin
            mix_acc = '0;
        end
        // seeding happens on any request that finds the state at zero
        if (xs_state == '0) begin
            xs_state = r.cycle_count ^ (r.tick_ms << SEED_TICK_SHIFT) ^ SEED_CONST;
        end
        if (hw_enabled && r.hw_ok) begin
            mix_acc ^= r.hw_word;
        end else begin
            xs_state ^= xs_state >> XS_SHIFT_A;
            xs_state ^= xs_state << XS_SHIFT_B;
            xs_state ^= xs_state >> XS_SHIFT_C;
            mix_acc  ^= word_t'(xs_state * STAR_MULT);
        end
        mix_acc ^= r.cycle_count ^ (r.tick_ms << MIX_TICK_SHIFT) ^ r.task_tag;
        res.out_word    = mix_acc;
        res.valid_bytes = (r.byte_count > BYTES_MAX) ? BYTES_MAX : r.byte_count;
        return res;
    endfunction

    // random request: mostly counter-like timestamps, short runs per fill
    function automatic request_t random_request();
        request_t r;
        r.first   = ($urandom_range(0, 3) == 0);
        r.hw_ok   = 1'($urandom_range(0, 1));
        r.hw_word = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) begin
            cycle_now += word_t'($urandom_range(1, 5000));
            r.cycle_count = cycle_now;
        end else begin
            r.cycle_count = {$urandom, $urandom};
        end
        r.tick_ms  = $urandom_range(0, 1) ? word_t'($urandom_range(0, 100000))
                                          : {$urandom, $urandom};
        r.task_tag = $urandom_range(0, 1) ? word_t'($urandom_range(1, 64))
                                          : {$urandom, $urandom};
        // byte counts outside 1..8 now and then
        r.byte_count = ($urandom_range(0, 7) != 0) ? bytes_t'($urandom_range(1, 8))
                                                   : bytes_t'($urandom_range(0, 15));
        return r;
    endfunction

    // offer one request after a random gap, return once it is taken
    task automatic send_request(input request_t r);
        int unsigned gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and wait until every predicted word has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_words.size() != 0);
    endtask

    // source flag write, only with the pipeline empty
    task automatic write_source_flag(input logic flag);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= flag;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        hw_enabled  = flag;
    endtask

    initial begin : stimulus
        mixed_word_t want;
        request_t    req;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, typed fields override the prediction
        foreach (dir_rows[i]) begin
            if (dir_rows[i].hw_cfg != hw_enabled) begin
                write_source_flag(dir_rows[i].hw_cfg);
            end
            send_request(dir_rows[i].req);
            want = mix_word(dir_rows[i].req);
            if (dir_rows[i].fixed_word) begin
                want.out_word = dir_rows[i].res.out_word;
            end
            if (dir_rows[i].fixed_bytes) begin
                want.valid_bytes = dir_rows[i].res.valid_bytes;
            end
            pending_words.push_back(want);
        end

        // random phases, source flag toggled between phases
        for (int p = 0; p < RAND_PHASES; p++) begin
            write_source_flag(p % 2 == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // stretches with and without idling on each side
                if (k % 64 == 0) begin
                    src_gap_max  = $urandom_range(0, 1) ? MAX_GAP : 0;
                    sink_gap_max = $urandom_range(0, 2) ? MAX_GAP : 0;
                end
                // sink holds off long while requests keep coming back to back
                if (p == 1 && k == 100) begin
                    src_gap_max = 0;
                    long_holds_asked++;
                end
                // source pauses until everything outstanding has come back
                if (p == 2 && k == 200) begin
                    wait_drained();
                end
                req = random_request();
                send_request(req);
                pending_words.push_back(mix_word(req));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // result sink: random stall after each taken result, plus the long hold
    always @(posedge aclk) begin : result_sink
        int unsigned w;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1) begin
                m_ready <= 1'b1;
            end
        end else if (long_holds_asked != long_holds_done) begin
            long_holds_done++;
            m_ready   <= 1'b0;
            hold_left <= LONG_HOLD;
        end else if (m_valid && m_ready) begin
            w = $urandom_range(0, sink_gap_max);
            if (w != 0) begin
                m_ready   <= 1'b0;
                hold_left <= w;
            end
        end else begin
            m_ready <= 1'b1;
        end
    end

    // in-order compare against the oldest predicted word
    always @(posedge aclk) begin : result_check
        mixed_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $error("result with no request outstanding: out_word %h", m_out_word);
                n_fail++;
            end else begin
                want = pending_words.pop_front();
                if (m_out_word !== want.out_word) begin
                    $error("out_word: expected %h, got %h", want.out_word, m_out_word);
                    n_fail++;
                end
                if (m_valid_bytes !== want.valid_bytes) begin
                    $error("valid_bytes: expected %0d, got %0d",
                           want.valid_bytes, m_valid_bytes);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
